@@ rtl/sths_pkg.sv @@
// shared widths, types and codes for the sorted table hunt search block
package sths_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_WIDTH   = 32;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W   = CNT_W + 3;
  localparam int INDEX_W = 8;
  localparam int GUESS_W = 10;
  localparam int POS_W   = 9;
  localparam int CFG_W   = 9;

  typedef logic signed [KEY_WIDTH-1:0] key_t;
  typedef logic signed [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [ADDR_W-1:0]           addr_t;

  localparam idx_t IDX_ZERO = idx_t'(0);
  localparam idx_t IDX_ONE  = idx_t'(1);

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic               start;
    key_t               key;
    logic [GUESS_W-1:0] guess;
    cnt_t               count;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cnt_t pos;
  } res_t;

endpackage

@@ rtl/sths_ram.sv @@
// generic single write port ram with registered read
module sths_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sths_cmp.sv @@
// shared key comparator used by every probe of the search
module sths_cmp (
  input  sths_pkg::key_t key,
  input  sths_pkg::key_t first,
  input  sths_pkg::key_t entry,
  input  logic           dir_mode,
  input  logic           ascend,
  output logic           ge,
  output logic           past
);

  sths_pkg::key_t a;

  // direction check compares the first entry against the last one
  assign a    = dir_mode ? first : key;
  assign ge   = (a >= entry);
  assign past = (ge == ascend);

endmodule

@@ rtl/sths_ctrl.sv @@
// search sequencer: direction check, gallop and bisection over the table ram
module sths_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  sths_pkg::cmd_t    cmd,
  input  logic              out_free,
  input  sths_pkg::key_t    rdata,
  output sths_pkg::addr_t   raddr,
  output logic              idle,
  output sths_pkg::res_t    res
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_LAST     = 12'b0000_0000_0010,
    S_DIR      = 12'b0000_0000_0100,
    S_NG_LAST  = 12'b0000_0000_1000,
    S_NG_FIRST = 12'b0000_0001_0000,
    S_G0       = 12'b0000_0010_0000,
    S_GUP      = 12'b0000_0100_0000,
    S_GEND_UP  = 12'b0000_1000_0000,
    S_GDN      = 12'b0001_0000_0000,
    S_GEND_DN  = 12'b0010_0000_0000,
    S_BIS      = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  sths_pkg::key_t key, first;
  sths_pkg::idx_t n, guess;
  sths_pkg::idx_t lo, hi, step, mid;
  sths_pkg::idx_t lo_next, hi_next, step_next, mid_next;
  sths_pkg::idx_t step2, hi2, lo2;
  sths_pkg::idx_t g_ext, cnt_ext;
  sths_pkg::idx_t rd_idx;
  sths_pkg::idx_t launch_lo, launch_hi, span, sum, fin_idx;
  sths_pkg::cnt_t pos, pos_next;
  logic           ascend, ascend_next;
  logic           have_guess, g_ok;
  logic           launch, fin;
  logic           cmp_ge, cmp_past;

  sths_cmp u_cmp (
    .key      (key),
    .first    (first),
    .entry    (rdata),
    .dir_mode (state == S_DIR),
    .ascend   (ascend),
    .ge       (cmp_ge),
    .past     (cmp_past)
  );

  assign g_ext   = sths_pkg::idx_t'(cmd.guess[sths_pkg::GUESS_W-2:0]);
  assign cnt_ext = sths_pkg::idx_t'(cmd.count);
  assign g_ok    = !cmd.guess[sths_pkg::GUESS_W-1] && (g_ext >= sths_pkg::IDX_ONE) &&
                   (g_ext <= cnt_ext - sths_pkg::IDX_ONE);

  assign step2 = step <<< 1;
  assign hi2   = hi + step2;
  assign lo2   = lo - step2;

  always_comb begin
    state_next  = state;
    lo_next     = lo;
    hi_next     = hi;
    step_next   = step;
    mid_next    = mid;
    pos_next    = pos;
    ascend_next = ascend;
    rd_idx      = sths_pkg::IDX_ZERO;
    launch      = 1'b0;
    launch_lo   = lo;
    launch_hi   = hi;
    fin         = 1'b0;
    fin_idx     = sths_pkg::IDX_ZERO;
    span        = sths_pkg::IDX_ZERO;
    sum         = sths_pkg::IDX_ZERO;

    unique case (state)
      S_IDLE: begin
        if (cmd.start) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        rd_idx     = n - sths_pkg::IDX_ONE;
        state_next = S_DIR;
      end
      S_DIR: begin
        ascend_next = !cmp_ge;
        if (have_guess) begin
          rd_idx     = guess;
          state_next = S_G0;
        end else begin
          rd_idx     = n - sths_pkg::IDX_ONE;
          state_next = S_NG_LAST;
        end
      end
      S_NG_LAST: begin
        if (cmp_past) begin
          fin     = 1'b1;
          fin_idx = n;
        end else begin
          state_next = S_NG_FIRST;
        end
      end
      S_NG_FIRST: begin
        if (!cmp_past) begin
          fin = 1'b1;
        end else begin
          launch    = 1'b1;
          launch_lo = sths_pkg::IDX_ZERO;
          launch_hi = n - sths_pkg::IDX_ONE;
        end
      end
      S_G0: begin
        if (cmp_past) begin
          if (guess == n - sths_pkg::IDX_ONE) begin
            fin     = 1'b1;
            fin_idx = n;
          end else begin
            lo_next    = guess;
            hi_next    = guess + sths_pkg::IDX_ONE;
            step_next  = sths_pkg::IDX_ONE;
            rd_idx     = guess + sths_pkg::IDX_ONE;
            state_next = S_GUP;
          end
        end else begin
          hi_next    = guess;
          lo_next    = guess - sths_pkg::IDX_ONE;
          step_next  = sths_pkg::IDX_ONE;
          rd_idx     = guess - sths_pkg::IDX_ONE;
          state_next = S_GDN;
        end
      end
      S_GUP: begin
        if (cmp_past) begin
          lo_next   = hi;
          step_next = step2;
          if (hi2 >= n) begin
            // ran off the end: settle against the last entry
            rd_idx     = n - sths_pkg::IDX_ONE;
            state_next = S_GEND_UP;
          end else begin
            hi_next = hi2;
            rd_idx  = hi2;
          end
        end else begin
          launch = 1'b1;
        end
      end
      S_GEND_UP: begin
        if (cmp_past) begin
          fin     = 1'b1;
          fin_idx = n;
        end else begin
          launch    = 1'b1;
          launch_hi = n;
        end
      end
      S_GDN: begin
        if (!cmp_past) begin
          hi_next   = lo;
          step_next = step2;
          if (lo2 < sths_pkg::IDX_ZERO) begin
            state_next = S_GEND_DN;
          end else begin
            lo_next = lo2;
            rd_idx  = lo2;
          end
        end else begin
          launch = 1'b1;
        end
      end
      S_GEND_DN: begin
        if (!cmp_past) begin
          fin = 1'b1;
        end else begin
          launch    = 1'b1;
          launch_lo = sths_pkg::IDX_ZERO;
        end
      end
      S_BIS: begin
        launch = 1'b1;
        if (cmp_past) begin
          launch_lo = mid;
        end else begin
          launch_hi = mid;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // bisect the bracket, probing its midpoint at once; span <= 1 ends at hi
    if (launch) begin
      lo_next = launch_lo;
      hi_next = launch_hi;
      span    = launch_hi - launch_lo;
      sum     = launch_lo + launch_hi;
      if (span > sths_pkg::IDX_ONE) begin
        mid_next   = sum >>> 1;
        rd_idx     = mid_next;
        state_next = S_BIS;
      end else begin
        pos_next   = launch_hi[sths_pkg::CNT_W-1:0];
        state_next = S_DONE;
      end
    end

    if (fin) begin
      pos_next   = fin_idx[sths_pkg::CNT_W-1:0];
      state_next = S_DONE;
    end
  end

  assign raddr     = rd_idx[sths_pkg::ADDR_W-1:0];
  assign idle      = (state == S_IDLE);
  assign res.valid = (state == S_DONE);
  assign res.pos   = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.start) begin
      key        <= cmd.key;
      n          <= cnt_ext;
      guess      <= g_ext;
      have_guess <= g_ok;
    end
    if (state == S_LAST) begin
      first <= rdata;
    end
    lo     <= lo_next;
    hi     <= hi_next;
    step   <= step_next;
    mid    <= mid_next;
    pos    <= pos_next;
    ascend <= ascend_next;
  end

  a_bis_bracket: assert property (@(posedge clk) disable iff (rst)
    state == S_BIS |-> (lo < mid) && (mid < hi))
    else $error("bisection midpoint outside its bracket");

  a_gallop_up: assert property (@(posedge clk) disable iff (rst)
    state == S_GUP |-> (lo >= sths_pkg::IDX_ZERO) && (lo < hi) && (hi < n))
    else $error("upward gallop probe outside the table");

  a_gallop_down: assert property (@(posedge clk) disable iff (rst)
    state == S_GDN |-> (lo >= sths_pkg::IDX_ZERO) && (lo < hi) && (hi < n))
    else $error("downward gallop probe outside the table");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> sths_pkg::idx_t'(pos) <= n)
    else $error("search result beyond the entry count");

endmodule

@@ rtl/sorted_table_hunt_search.sv @@
// top level: handshakes, entry count register, table ram and result register
// a load is written to the table ram as it is taken and gives no result
// a search reads the first and last entries for the direction check, then gallops from a valid
// guess or takes the whole table without one, and bisects the bracket; its result is registered
// one item is in work at a time; each probe is one read of the single table ram port
// reset clears the sequencer and output valid and sets the entry count to 1;
// table contents stay undefined until loaded
module sorted_table_hunt_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                func,
  input  logic [sths_pkg::INDEX_W-1:0]        entry_index,
  input  logic signed [sths_pkg::KEY_WIDTH-1:0] entry_value,
  input  logic signed [sths_pkg::KEY_WIDTH-1:0] search_key,
  input  logic signed [sths_pkg::GUESS_W-1:0] start_guess,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [sths_pkg::POS_W-1:0]          position,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sths_pkg::CFG_W-1:0]          cfg_data
);

  sths_pkg::cnt_t  count;
  sths_pkg::cnt_t  count_next;
  logic [sths_pkg::IDX_W-1:0] cfg_ext;
  logic            item_take;
  logic            ram_we;
  sths_pkg::addr_t ram_waddr, ram_raddr;
  logic [sths_pkg::KEY_WIDTH-1:0] ram_rdata;
  sths_pkg::key_t  rdata;
  sths_pkg::cmd_t  cmd;
  sths_pkg::res_t  res;
  logic            idle;
  logic            out_free;

  assign item_stall = !idle;
  assign item_take  = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  // count of zero acts as one, anything past the table depth is clipped
  assign cfg_ext = sths_pkg::IDX_W'(cfg_data);
  always_comb begin
    priority if (cfg_ext == '0) begin
      count_next = sths_pkg::cnt_t'(1);
    end else if (cfg_ext > sths_pkg::IDX_W'(sths_pkg::TABLE_DEPTH)) begin
      count_next = sths_pkg::CNT_W'(sths_pkg::TABLE_DEPTH);
    end else begin
      count_next = cfg_ext[sths_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= sths_pkg::cnt_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      count <= count_next;
    end
  end

  // loads beyond the table depth are dropped
  assign ram_we    = item_take && (func == sths_pkg::FUNC_LOAD) &&
                     (sths_pkg::IDX_W'(entry_index) < sths_pkg::IDX_W'(sths_pkg::TABLE_DEPTH));
  assign ram_waddr = sths_pkg::ADDR_W'(entry_index);

  sths_ram #(
    .WIDTH (sths_pkg::KEY_WIDTH),
    .DEPTH (sths_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (entry_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rdata = sths_pkg::key_t'(ram_rdata);

  assign cmd.start = item_take && (func == sths_pkg::FUNC_SEARCH);
  assign cmd.key   = search_key;
  assign cmd.guess = start_guess;
  assign cmd.count = count;

  sths_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .out_free (out_free),
    .rdata    (rdata),
    .raddr    (ram_raddr),
    .idle     (idle),
    .res      (res)
  );

  // result register frees up on the same edge as its transfer
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res.valid && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      position <= sths_pkg::POS_W'(res.pos);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= sths_pkg::cnt_t'(1)) && (count <= sths_pkg::CNT_W'(sths_pkg::TABLE_DEPTH)))
    else $error("entry count out of range");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res.valid && out_free |=> result_valid)
    else $error("finished search not registered");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> item_stall)
    else $error("search started but input not held off");

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the sorted table hunt search block
module tb_top;
  import sths_pkg::*;

  localparam key_t KEY_LO = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  localparam key_t KEY_HI = {1'b0, {(KEY_WIDTH-1){1'b1}}};
  localparam int SETTLE = 30;

  typedef logic [GUESS_W-1:0] guess_t;
  typedef enum {ASCENDING, ASCENDING_REPEATS, DESCENDING, FLAT, SCRAMBLED} shape_e;

  // keeps a copy of the table and count, works out the bracket for each search
  class hunt_checker;
    key_t entries [TABLE_DEPTH];
    int   count = 1;
    bit   ascend;
    int   positions_due [$];
    int   errors = 0;
    int   checked = 0;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_count(logic [CFG_W-1:0] v);
      count = (v == 0) ? 1 : (v > TABLE_DEPTH) ? TABLE_DEPTH : int'(v);
    endfunction

    function bit past(key_t k, int i);
      return (k >= entries[i]) == ascend;
    endfunction

    function bit ahead(key_t k, int i);
      return (k < entries[i]) == ascend;
    endfunction

    function int bracket_of(key_t k, guess_t g);
      int n, lo, hi, gs, step, mid;
      bit use_guess, fin;
      n = count;
      ascend = entries[n-1] > entries[0];
      use_guess = !g[GUESS_W-1] && g != 0 && int'(g) <= n - 1;
      gs = int'(g[GUESS_W-2:0]);
      step = 1;
      fin = 1'b0;
      if (!use_guess) begin
        if (past(k, n - 1)) return n;
        if (ahead(k, 0)) return 0;
        lo = 0;
        hi = n - 1;
      end else if (past(k, gs)) begin
        if (gs == n - 1) return n;
        lo = gs;
        hi = gs + 1;
        // gallop upwards, doubling the stride
        while (!fin && past(k, hi)) begin
          lo = hi;
          step += step;
          hi += step;
          if (hi >= n) begin
            if (past(k, n - 1)) return n;
            hi = n;
            fin = 1'b1;
          end
        end
      end else begin
        hi = gs;
        lo = gs - 1;
        while (!fin && ahead(k, lo)) begin
          hi = lo;
          step += step;
          lo -= step;
          if (lo < 0) begin
            if (ahead(k, 0)) return 0;
            lo = 0;
            fin = 1'b1;
          end
        end
      end
      while (hi - lo > 1) begin
        mid = (lo + hi) >>> 1;
        if (past(k, mid)) lo = mid;
        else hi = mid;
      end
      return hi;
    endfunction

    function void take_item(logic f, logic [INDEX_W-1:0] idx, key_t val, key_t k, guess_t g);
      if (f == FUNC_LOAD) entries[idx] = val;
      else positions_due.push_back(bracket_of(k, g));
    endfunction

    task check_position(logic [POS_W-1:0] p);
      int want;
      checked++;
      if (positions_due.size() == 0) begin
        report($sformatf("position %0d with no search outstanding", p));
      end else begin
        want = positions_due.pop_front();
        if (p !== POS_W'(want))
          report($sformatf("position %0d, predicted %0d", p, want));
      end
    endtask

    function int pending();
      return positions_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  logic                 func;
  logic [INDEX_W-1:0]   entry_index;
  key_t                 entry_value;
  key_t                 search_key;
  logic signed [GUESS_W-1:0] start_guess;
  logic                 result_valid;
  logic                 result_stall;
  logic [POS_W-1:0]     position;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data;

  hunt_checker chk = new();
  bit no_gaps = 1'b0;
  int n_loads = 0;
  int n_searches = 0;
  int n_settings = 0;

  sorted_table_hunt_search uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .search_key   (search_key),
    .start_guess  (start_guess),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .position     (position),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic send_item(logic f, logic [INDEX_W-1:0] idx, key_t val, key_t k, guess_t g);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid  = 1'b1;
    func        = f;
    entry_index = idx;
    entry_value = val;
    search_key  = k;
    start_guess = g;
    do @(posedge clk); while (item_stall !== 1'b0);
    chk.take_item(f, idx, val, k, g);
    if (f == FUNC_LOAD) n_loads++;
    else n_searches++;
  endtask

  // unused fields carry random bits on every transfer
  task automatic load_entry(int idx, key_t val);
    send_item(FUNC_LOAD, INDEX_W'(idx), val, key_t'($urandom), guess_t'($urandom));
  endtask

  task automatic search(key_t k, guess_t g);
    send_item(FUNC_SEARCH, INDEX_W'($urandom), key_t'($urandom), k, g);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid = 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    // a trailing load may still be in flight
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    chk.set_count(v);
    n_settings++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic fill_table(shape_e shape, int n);
    longint cur, room;
    key_t v, level;
    int i;
    cur   = longint'(KEY_LO) + longint'($urandom_range(0, 32'h7FFF_FFFF));
    room  = (longint'(KEY_HI) - cur) / n;
    level = key_t'($urandom);
    for (i = 0; i < n; i++) begin
      case (shape)
        ASCENDING, ASCENDING_REPEATS: v = key_t'(cur);
        DESCENDING: v = ~key_t'(cur);
        FLAT: v = level;
        default: v = key_t'($urandom);
      endcase
      load_entry(i, v);
      if (shape == ASCENDING_REPEATS) cur += longint'($urandom_range(0, 1));
      else cur += longint'($urandom_range(1, 32'(room)));
    end
  endtask

  // mostly keys at or next to table entries, where brackets change
  function automatic key_t pick_key(int n);
    key_t base;
    base = chk.entries[$urandom_range(0, n - 1)];
    case ($urandom_range(0, 7))
      0, 1, 2: return base;
      3: return base + 1;
      4: return base - 1;
      5: return KEY_LO;
      6: return KEY_HI;
      default: return key_t'($urandom);
    endcase
  endfunction

  function automatic guess_t pick_guess(int n);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return guess_t'(n);
      3: return guess_t'($urandom);
      default: return guess_t'($urandom_range(1, (n > 1) ? n - 1 : 1));
    endcase
  endfunction

  // result side: random hold-off before each transfer
  always begin : result_side
    int hold;
    hold = no_gaps ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (hold > 0) begin
      result_stall = 1'b1;
      repeat (hold) @(negedge clk);
    end
    result_stall = 1'b0;
    do @(posedge clk); while (result_valid !== 1'b1);
    chk.check_position(position);
  end

  initial begin : run
    int i, j, n, p;
    logic [CFG_W-1:0] cv;
    shape_e shape;
    rst          = 1'b1;
    item_valid   = 1'b0;
    func         = FUNC_LOAD;
    entry_index  = '0;
    entry_value  = '0;
    search_key   = '0;
    start_guess  = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single entry table
    write_count(1);
    load_entry(0, '0);
    search(KEY_LO, '1);
    search('0, '0);
    search(KEY_HI, guess_t'(1));
    search('0, guess_t'(10'h200));
    drain();
    write_count(0);
    search(-1, guess_t'(256));
    drain();

    // full ascending table from the lowest key to the highest
    for (i = 0; i < TABLE_DEPTH; i++)
      load_entry(i, (i == TABLE_DEPTH - 1) ? KEY_HI :
                 key_t'(longint'(KEY_LO) + longint'(i) * 16777215));
    drain();
    write_count('1);
    search(KEY_LO, '0);
    search(KEY_HI, guess_t'(255));
    search(chk.entries[100], guess_t'(1));
    search(chk.entries[0], guess_t'(255));
    search(chk.entries[255], '1);
    search(chk.entries[254], guess_t'(254));
    search(chk.entries[77] + 5, guess_t'(128));
    search(chk.entries[200], guess_t'(256));
    search(chk.entries[3] - 1, guess_t'(10'h1FF));
    search(chk.entries[128], guess_t'(10'h200));
    drain();
    write_count(256);
    search(chk.entries[255] - 1, guess_t'(2));
    search(chk.entries[1], guess_t'(254));

    // random table settings
    for (p = 0; p < 5; p++) begin
      drain();
      case ($urandom_range(0, 9))
        0: n = TABLE_DEPTH;
        1: n = $urandom_range(1, 2);
        default: n = $urandom_range(3, 40);
      endcase
      cv = CFG_W'(n);
      if (n == 1 && $urandom_range(0, 1) == 1) cv = '0;
      if (n == TABLE_DEPTH && $urandom_range(0, 1) == 1) cv = CFG_W'($urandom_range(257, 511));
      shape   = shape_e'($urandom_range(0, 4));
      no_gaps = ($urandom_range(0, 3) == 0);
      write_count(cv);
      fill_table(shape, n);
      for (j = 0; j < 45; j++) begin
        if ($urandom_range(0, 9) == 0)
          load_entry($urandom_range(0, TABLE_DEPTH - 1), key_t'($urandom));
        else
          search(pick_key(n), pick_guess(n));
      end
    end
    drain();

    $display("covered %0d loads and %0d searches across %0d count settings",
             n_loads, n_searches, n_settings);
    $display("%0d positions checked, %0d mismatches", chk.checked, chk.errors);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("[sorted_table_hunt_search] OK");
    end else begin
      $display("[sorted_table_hunt_search] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("[sorted_table_hunt_search] ERROR");
    $finish;
  end

endmodule

@@ sorted_table_hunt_search.f @@
rtl/sths_pkg.sv
rtl/sths_ram.sv
rtl/sths_cmp.sv
rtl/sths_ctrl.sv
rtl/sorted_table_hunt_search.sv
tb/tb_top.sv
